[design/jp2mh_pkg.sv]
package jp2mh_pkg;

  // One codestream byte per beat
  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_stream;
  } jp2mh_in_t;

  // One header summary per stream
  typedef struct packed {
    logic        header_valid;
    logic [1:0]  status_code;
    logic [15:0] profile;
    logic [31:0] image_width;
    logic [31:0] image_height;
    logic [15:0] component_count;
    logic [7:0]  sample_depth;
    logic [8:0]  resolution_count;
    logic        irreversible;
  } jp2mh_out_t;

  // Parser phases
  localparam logic [2:0] PH_SOC_HI  = 3'd0;
  localparam logic [2:0] PH_SOC_LO  = 3'd1;
  localparam logic [2:0] PH_MARK_HI = 3'd2;
  localparam logic [2:0] PH_MARK_LO = 3'd3;
  localparam logic [2:0] PH_LEN_HI  = 3'd4;
  localparam logic [2:0] PH_LEN_LO  = 3'd5;
  localparam logic [2:0] PH_BODY    = 3'd6;
  localparam logic [2:0] PH_STOP    = 3'd7;

  // Markers
  localparam logic [15:0] MARK_SOC = 16'hFF4F;
  localparam logic [15:0] MARK_SIZ = 16'hFF51;
  localparam logic [15:0] MARK_COD = 16'hFF52;
  localparam logic [15:0] MARK_SOT = 16'hFF90;

  localparam logic [6:0] DEPTH_MASK = 7'h7F;

  // Minimum data byte counts; Lseg counts its own two bytes on top
  localparam logic [15:0] SIZ_MIN_DATA   = 16'd36;
  localparam logic [15:0] SIZ_DEPTH_DATA = 16'd38;
  localparam logic [15:0] COD_MIN_DATA   = 16'd9;
  localparam logic [15:0] COD_XFORM_DATA = 16'd12;
  localparam logic [15:0] LSEG_SELF      = 16'd2;

  // Byte offsets inside segment data
  localparam logic [15:0] SIZ_RSIZ_LAST  = 16'd1;
  localparam logic [15:0] SIZ_XSIZ_LAST  = 16'd5;
  localparam logic [15:0] SIZ_YSIZ_LAST  = 16'd9;
  localparam logic [15:0] SIZ_CSIZ_HI    = 16'd34;
  localparam logic [15:0] SIZ_CSIZ_LO    = 16'd35;
  localparam logic [15:0] SIZ_SSIZ0      = 16'd36;
  localparam logic [15:0] COD_LEVELS_OFS = 16'd5;
  localparam logic [15:0] COD_XFORM_OFS  = 16'd9;

  localparam logic [2:0] LEAD_MIN = 3'd4;

  // Error codes
  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_SHORT   = 2'd1;
  localparam logic [1:0] ERR_NO_SOC  = 2'd2;
  localparam logic [1:0] ERR_NO_SIZ  = 2'd3;

endpackage

[design/jpeg2000_main_header_parser.sv]
// JPEG 2000 main header parser.
// Input channel (in_valid / in_stall / in_data): one codestream byte per beat,
// with end_of_stream set on the last byte of a stream. The first two bytes must
// be SOC; marker segments are then walked by their Lseg. SIZ and COD fields are
// staged while a segment streams in and committed once its last byte arrives.
// Parsing halts at SOT, at an Lseg below 2, or at a missing SOC; later bytes of
// the stream are dropped.
// Result channel (out_valid / out_stall / out_data): exactly one beat per
// stream, registered, in the cycle after the end_of_stream byte is accepted.
// Throughput: one byte per cycle, set by a single state update per byte.
// A byte without end_of_stream is always taken, even while a result waits;
// only an end_of_stream byte is held off while the result register is full
// and stalled. After the result the parser is back in its start state, so
// the next stream may follow in the next cycle.
// Reset (rst_n low, synchronous) clears the parser and empties the result
// register; staging registers are loaded before they are read.
module jpeg2000_main_header_parser (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  jp2mh_pkg::jp2mh_in_t   in_data,
  output logic                   out_valid,
  input  logic                   out_stall,
  output jp2mh_pkg::jp2mh_out_t  out_data
);
  import jp2mh_pkg::*;

  // Parser control state
  logic [2:0]  phase_r, phase_nxt;
  logic [2:0]  lead_cnt_r, lead_cnt_nxt;
  logic        soc_ok_r, soc_ok_nxt;
  logic [15:0] mark_r, mark_nxt;
  logic [15:0] seg_len_r, seg_len_nxt;
  logic [15:0] seg_ofs_r, seg_ofs_nxt;
  logic        siz_found_r, siz_found_nxt;

  // Staging for the segment in flight (no reset)
  logic [15:0] stg_rsiz_r, stg_rsiz_nxt;
  logic [31:0] stg_xsiz_r, stg_xsiz_nxt;
  logic [31:0] stg_ysiz_r, stg_ysiz_nxt;
  logic [15:0] stg_csiz_r, stg_csiz_nxt;
  logic [7:0]  stg_ssiz_r, stg_ssiz_nxt;
  logic [7:0]  stg_levels_r, stg_levels_nxt;
  logic [7:0]  stg_xform_r, stg_xform_nxt;

  // Committed header fields
  logic [15:0] cm_prof_r, cm_prof_nxt;
  logic [31:0] cm_wid_r, cm_wid_nxt;
  logic [31:0] cm_hgt_r, cm_hgt_nxt;
  logic [15:0] cm_comp_r, cm_comp_nxt;
  logic [7:0]  cm_depth_r, cm_depth_nxt;
  logic [8:0]  cm_res_r, cm_res_nxt;
  logic        cm_irr_r, cm_irr_nxt;

  // Post-byte values before the end-of-stream restart
  logic [2:0]  upd_phase, upd_lead;
  logic        upd_soc_ok, upd_siz_found;
  logic [15:0] upd_mark, upd_len, upd_ofs;
  logic [15:0] upd_prof, upd_comp;
  logic [31:0] upd_wid, upd_hgt;
  logic [7:0]  upd_depth;
  logic [8:0]  upd_res;
  logic        upd_irr;

  // Result register
  logic        out_valid_r, out_valid_nxt;
  jp2mh_out_t  out_data_r, out_data_nxt, result;

  logic        in_acc, last_byte, seg_end;
  logic [7:0]  b;
  logic [15:0] data_len;

  assign b         = in_data.data_byte;
  assign last_byte = in_data.end_of_stream;
  // Hold an end-of-stream byte only while the finished result is stuck
  assign in_stall  = out_valid_r & out_stall & last_byte;
  assign in_acc    = in_valid & ~in_stall;
  assign data_len  = seg_len_r - LSEG_SELF;
  assign seg_end   = ({1'b0, seg_ofs_r} + 17'd3) == {1'b0, seg_len_r};

  always_comb begin
    upd_phase     = phase_r;
    upd_lead      = (lead_cnt_r < LEAD_MIN) ? lead_cnt_r + 3'd1 : lead_cnt_r;
    upd_soc_ok    = soc_ok_r;
    upd_mark      = mark_r;
    upd_len       = seg_len_r;
    upd_ofs       = seg_ofs_r;
    upd_siz_found = siz_found_r;
    upd_prof      = cm_prof_r;
    upd_wid       = cm_wid_r;
    upd_hgt       = cm_hgt_r;
    upd_comp      = cm_comp_r;
    upd_depth     = cm_depth_r;
    upd_res       = cm_res_r;
    upd_irr       = cm_irr_r;

    stg_rsiz_nxt   = stg_rsiz_r;
    stg_xsiz_nxt   = stg_xsiz_r;
    stg_ysiz_nxt   = stg_ysiz_r;
    stg_csiz_nxt   = stg_csiz_r;
    stg_ssiz_nxt   = stg_ssiz_r;
    stg_levels_nxt = stg_levels_r;
    stg_xform_nxt  = stg_xform_r;

    case (phase_r)
      PH_SOC_HI: begin
        upd_mark  = {b, 8'h00};
        upd_phase = PH_SOC_LO;
      end
      PH_SOC_LO: begin
        upd_mark = {mark_r[15:8], b};
        if ({mark_r[15:8], b} == MARK_SOC) begin
          upd_soc_ok = 1'b1;
          upd_phase  = PH_MARK_HI;
        end else begin
          upd_phase = PH_STOP;
        end
      end
      PH_MARK_HI: begin
        upd_mark  = {b, 8'h00};
        upd_phase = PH_MARK_LO;
      end
      PH_MARK_LO: begin
        upd_mark  = {mark_r[15:8], b};
        upd_phase = ({mark_r[15:8], b} == MARK_SOT) ? PH_STOP : PH_LEN_HI;
      end
      PH_LEN_HI: begin
        upd_len   = {b, 8'h00};
        upd_phase = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        upd_len = {seg_len_r[15:8], b};
        upd_ofs = '0;
        if ({seg_len_r[15:8], b} < LSEG_SELF) begin
          upd_phase = PH_STOP;
        end else if ({seg_len_r[15:8], b} == LSEG_SELF) begin
          upd_phase = PH_MARK_HI;
        end else begin
          upd_phase = PH_BODY;
        end
      end
      PH_BODY: begin
        // Shift the byte into the field its offset belongs to
        if (mark_r == MARK_SIZ) begin
          if (seg_ofs_r <= SIZ_RSIZ_LAST) begin
            stg_rsiz_nxt = {stg_rsiz_r[7:0], b};
          end else if (seg_ofs_r <= SIZ_XSIZ_LAST) begin
            stg_xsiz_nxt = {stg_xsiz_r[23:0], b};
          end else if (seg_ofs_r <= SIZ_YSIZ_LAST) begin
            stg_ysiz_nxt = {stg_ysiz_r[23:0], b};
          end else if (seg_ofs_r inside {SIZ_CSIZ_HI, SIZ_CSIZ_LO}) begin
            stg_csiz_nxt = {stg_csiz_r[7:0], b};
          end else if (seg_ofs_r == SIZ_SSIZ0) begin
            stg_ssiz_nxt = b;
          end
        end else if (mark_r == MARK_COD) begin
          if (seg_ofs_r == COD_LEVELS_OFS) begin
            stg_levels_nxt = b;
          end else if (seg_ofs_r == COD_XFORM_OFS) begin
            stg_xform_nxt = b;
          end
        end
        if (seg_end) begin
          // Last byte of the segment: commit what it covers
          if (mark_r == MARK_SIZ && data_len >= SIZ_MIN_DATA) begin
            upd_prof      = stg_rsiz_nxt;
            upd_wid       = stg_xsiz_nxt;
            upd_hgt       = stg_ysiz_nxt;
            upd_comp      = stg_csiz_nxt;
            upd_siz_found = 1'b1;
            if (data_len >= SIZ_DEPTH_DATA) begin
              upd_depth = {1'b0, stg_ssiz_nxt[6:0] & DEPTH_MASK} + 8'd1;
            end
          end else if (mark_r == MARK_COD && data_len >= COD_MIN_DATA) begin
            upd_res = {1'b0, stg_levels_nxt} + 9'd1;
            if (data_len >= COD_XFORM_DATA) begin
              upd_irr = (stg_xform_nxt == 8'h00);
            end
          end
          upd_phase = PH_MARK_HI;
        end else begin
          upd_ofs = seg_ofs_r + 16'd1;
        end
      end
      default: begin
        // Stopped: drop bytes until end of stream
      end
    endcase
  end

  // Summary for this stream, taken after the final byte is applied
  always_comb begin
    result = '0;
    if (upd_lead < LEAD_MIN) begin
      result.status_code = ERR_SHORT;
    end else if (!upd_soc_ok) begin
      result.status_code = ERR_NO_SOC;
    end else begin
      result.header_valid     = upd_siz_found;
      result.status_code      = upd_siz_found ? ERR_NONE : ERR_NO_SIZ;
      result.profile          = upd_prof;
      result.image_width      = upd_wid;
      result.image_height     = upd_hgt;
      result.component_count  = upd_comp;
      result.sample_depth     = upd_depth;
      result.resolution_count = upd_res;
      result.irreversible     = upd_irr;
    end
  end

  always_comb begin
    phase_nxt     = phase_r;
    lead_cnt_nxt  = lead_cnt_r;
    soc_ok_nxt    = soc_ok_r;
    mark_nxt      = mark_r;
    seg_len_nxt   = seg_len_r;
    seg_ofs_nxt   = seg_ofs_r;
    siz_found_nxt = siz_found_r;
    cm_prof_nxt   = cm_prof_r;
    cm_wid_nxt    = cm_wid_r;
    cm_hgt_nxt    = cm_hgt_r;
    cm_comp_nxt   = cm_comp_r;
    cm_depth_nxt  = cm_depth_r;
    cm_res_nxt    = cm_res_r;
    cm_irr_nxt    = cm_irr_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r & out_stall;
    if (in_acc) begin
      if (last_byte) begin
        // Emit the summary and restart for the next stream
        out_valid_nxt = 1'b1;
        out_data_nxt  = result;
        phase_nxt     = PH_SOC_HI;
        lead_cnt_nxt  = '0;
        soc_ok_nxt    = 1'b0;
        mark_nxt      = '0;
        seg_len_nxt   = '0;
        seg_ofs_nxt   = '0;
        siz_found_nxt = 1'b0;
        cm_prof_nxt   = '0;
        cm_wid_nxt    = '0;
        cm_hgt_nxt    = '0;
        cm_comp_nxt   = '0;
        cm_depth_nxt  = '0;
        cm_res_nxt    = '0;
        cm_irr_nxt    = 1'b0;
      end else begin
        phase_nxt     = upd_phase;
        lead_cnt_nxt  = upd_lead;
        soc_ok_nxt    = upd_soc_ok;
        mark_nxt      = upd_mark;
        seg_len_nxt   = upd_len;
        seg_ofs_nxt   = upd_ofs;
        siz_found_nxt = upd_siz_found;
        cm_prof_nxt   = upd_prof;
        cm_wid_nxt    = upd_wid;
        cm_hgt_nxt    = upd_hgt;
        cm_comp_nxt   = upd_comp;
        cm_depth_nxt  = upd_depth;
        cm_res_nxt    = upd_res;
        cm_irr_nxt    = upd_irr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_SOC_HI;
      lead_cnt_r  <= '0;
      soc_ok_r    <= 1'b0;
      mark_r      <= '0;
      seg_len_r   <= '0;
      seg_ofs_r   <= '0;
      siz_found_r <= 1'b0;
      cm_prof_r   <= '0;
      cm_wid_r    <= '0;
      cm_hgt_r    <= '0;
      cm_comp_r   <= '0;
      cm_depth_r  <= '0;
      cm_res_r    <= '0;
      cm_irr_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      lead_cnt_r  <= lead_cnt_nxt;
      soc_ok_r    <= soc_ok_nxt;
      mark_r      <= mark_nxt;
      seg_len_r   <= seg_len_nxt;
      seg_ofs_r   <= seg_ofs_nxt;
      siz_found_r <= siz_found_nxt;
      cm_prof_r   <= cm_prof_nxt;
      cm_wid_r    <= cm_wid_nxt;
      cm_hgt_r    <= cm_hgt_nxt;
      cm_comp_r   <= cm_comp_nxt;
      cm_depth_r  <= cm_depth_nxt;
      cm_res_r    <= cm_res_nxt;
      cm_irr_r    <= cm_irr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Staging and result payload carry no reset
  always_ff @(posedge clk) begin
    if (in_acc) begin
      stg_rsiz_r   <= stg_rsiz_nxt;
      stg_xsiz_r   <= stg_xsiz_nxt;
      stg_ysiz_r   <= stg_ysiz_nxt;
      stg_csiz_r   <= stg_csiz_nxt;
      stg_ssiz_r   <= stg_ssiz_nxt;
      stg_levels_r <= stg_levels_nxt;
      stg_xform_r  <= stg_xform_nxt;
    end
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTH
  a_restart_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && last_byte |=> out_valid_r && phase_r == PH_SOC_HI && lead_cnt_r == 3'd0)
    else $error("parser did not restart after end of stream");

  a_lead_saturates: assert property (@(posedge clk) disable iff (!rst_n)
    lead_cnt_r <= LEAD_MIN)
    else $error("lead byte count overran");

  a_valid_means_no_error: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.header_valid |-> out_data_r.status_code == ERR_NONE)
    else $error("header flagged valid with an error code");

  a_body_length: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_BODY |-> seg_len_r > LSEG_SELF && seg_ofs_r < seg_len_r)
    else $error("segment body entered with a bad length");

  a_soc_seen_late: assert property (@(posedge clk) disable iff (!rst_n)
    soc_ok_r |-> lead_cnt_r >= 3'd2)
    else $error("SOC flagged before two bytes arrived");
`endif

endmodule
